// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, reset included.
`define AP_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset.
`define AP_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/core/apf_pkg.sv -----
// Types and constants shared by the box pair finder.
package apf_pkg;

  localparam int unsigned IDX_W       = 6;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned IN_Q_DEPTH  = 2;
  localparam int unsigned OUT_Q_DEPTH = 2;

  typedef struct packed {
    logic                       new_frame;
    logic signed [COORD_W-1:0]  box_min_x;
    logic signed [COORD_W-1:0]  box_min_y;
    logic signed [COORD_W-1:0]  box_max_x;
    logic signed [COORD_W-1:0]  box_max_y;
    logic                       is_static;
  } body_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic             last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  min_x;
    logic signed [COORD_W-1:0]  min_y;
    logic signed [COORD_W-1:0]  max_x;
    logic signed [COORD_W-1:0]  max_y;
    logic                       is_static;
  } box_t;

  typedef struct packed {
    logic  push;
    pair_t data;
  } pair_wr_t;

endpackage

// ----- rtl/core/apf_ram.sv -----
// Generic single write, single read RAM with registered read data.
module apf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/apf_fifo.sv -----
// Small register queue with full and empty flags.
module apf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/apf_back.sv -----
// Scan engine: compares a new box with the stored boxes and emits pairs.
module apf_back import apf_pkg::*; #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_empty,
  input  body_t    in_data,
  output logic     in_pop,
  input  logic     out_full,
  output pair_wr_t out_wr
);

  localparam int unsigned AW = $clog2(MAX_BODIES);
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] issue_idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic          pend_valid;
  logic [AW-1:0] pend_idx;
  box_t          cur;

  box_t          rd_box;
  logic          rd_en;
  logic          wr_en;
  logic          overlap;
  logic          hit;
  logic          stall;
  logic          more;
  logic          flush_go;
  logic [CW-1:0] count_eff;

  apf_ram #(
    .WIDTH ($bits(box_t)),
    .DEPTH (MAX_BODIES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (cur),
    .re    (rd_en),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_box)
  );

  always_comb begin
    overlap = ($signed(rd_box.min_x) <= $signed(cur.max_x)) &&
              ($signed(cur.min_x) <= $signed(rd_box.max_x)) &&
              ($signed(rd_box.min_y) <= $signed(cur.max_y)) &&
              ($signed(cur.min_y) <= $signed(rd_box.max_y));
    hit       = (state == S_SCAN) && cmp_valid && overlap &&
                !(rd_box.is_static && cur.is_static);
    stall     = hit && pend_valid && out_full;
    more      = (issue_idx != count);
    rd_en     = (state == S_SCAN) && !stall && more;
    flush_go  = (state == S_FLUSH) && (!pend_valid || !out_full);
    wr_en     = flush_go;
    in_pop    = (state == S_IDLE) && !in_empty;
    count_eff = in_data.new_frame ? '0 : count;

    out_wr.push           = 1'b0;
    out_wr.data.index_a   = IDX_W'(pend_idx);
    out_wr.data.index_b   = IDX_W'(count);
    out_wr.data.last_pair = 1'b0;
    if (state == S_SCAN) begin
      out_wr.push = hit && pend_valid && !out_full;
    end else if (state == S_FLUSH) begin
      out_wr.push           = pend_valid && !out_full;
      out_wr.data.last_pair = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      cur.min_x     <= in_data.box_min_x;
      cur.min_y     <= in_data.box_min_y;
      cur.max_x     <= in_data.box_max_x;
      cur.max_y     <= in_data.box_max_y;
      cur.is_static <= in_data.is_static;
    end
    if (rd_en) begin
      cmp_idx <= issue_idx[AW-1:0];
    end
    if (hit && !stall) begin
      pend_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      issue_idx  <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_pop) begin
            count      <= count_eff;
            issue_idx  <= '0;
            cmp_valid  <= 1'b0;
            pend_valid <= 1'b0;
            if (count_eff < CW'(MAX_BODIES)) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!stall) begin
            cmp_valid <= rd_en;
            if (rd_en) begin
              issue_idx <= issue_idx + 1'b1;
            end
            if (hit) begin
              pend_valid <= 1'b1;
            end
            if (!more) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (flush_go) begin
            pend_valid <= 1'b0;
            count      <= count + 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/aabb_pair_finder_top.sv -----
// Top level of the axis-aligned box pair finder.
// Each request brings one body's box; the block compares it with every box
// stored since the last new_frame, oldest first, and queues one pair per
// overlap unless both bodies are static, with last_pair set on the final one.
// The store has one read port and is read one box per cycle while the scan
// is not stalled; a full result queue stalls the scan. Bodies arriving once
// MAX_BODIES are stored are dropped without pairs. Pairs leave at up to one
// per cycle.
module aabb_pair_finder_top import apf_pkg::*; #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  body_t body,
  output logic  full,
  input  logic  pop,
  output pair_t pair,
  output logic  empty
);

  body_t    q_body;
  logic     q_empty;
  logic     q_pop;
  logic     r_full;
  pair_wr_t r_wr;

  apf_fifo #(
    .WIDTH ($bits(body_t)),
    .DEPTH (IN_Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (body),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_body),
    .empty (q_empty)
  );

  apf_back #(
    .MAX_BODIES (MAX_BODIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (q_empty),
    .in_data  (q_body),
    .in_pop   (q_pop),
    .out_full (r_full),
    .out_wr   (r_wr)
  );

  apf_fifo #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_wr.push),
    .wdata (r_wr.data),
    .full  (r_full),
    .pop   (pop),
    .rdata (pair),
    .empty (empty)
  );

endmodule

// ----- rtl/core/apf_checker.sv -----
// Port-level checks for the box pair finder, bound to the top level.
`include "assert_macros.svh"

module apf_checker import apf_pkg::*; #(
  parameter int unsigned MAX_BODIES = 64
) (
  input logic  clk,
  input logic  rst,
  input logic  full,
  input logic  pop,
  input pair_t pair,
  input logic  empty
);

  logic hold_req;
  logic order_ok;

  assign hold_req = !empty && !pop;
  assign order_ok = empty || (MAX_BODIES > 64) || (pair.index_a < pair.index_b);

  `AP_ASSERT(a_rst_empty, clk, rst |=> empty, "results present after reset")
  `AP_ASSERT(a_rst_full, clk, rst |=> !full, "full after reset")
  `AP_ASSERT_RST(a_hold, clk, rst, hold_req |=> !empty && $stable(pair), "held result changed")
  `AP_ASSERT_RST(a_order, clk, rst, order_ok, "pair not older-then-newer")

endmodule

bind aabb_pair_finder_top apf_checker #(
  .MAX_BODIES (MAX_BODIES)
) u_apf_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .pop   (pop),
  .pair  (pair),
  .empty (empty)
);
